### rtl/mts_pkg.sv
package mts_pkg;

    localparam int ValueWidth = 32;
    localparam int EntryWidth = 2 * ValueWidth;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef struct packed {
        logic signed [ValueWidth-1:0] top_value;
        logic signed [ValueWidth-1:0] min_value;
        err_t                         error_code;
    } result_t;

endpackage

### rtl/mts_ram.sv
module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AddrWidth-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [AddrWidth-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mts_ctrl.sv
module mts_ctrl
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    localparam int CountWidth = $clog2(STACK_DEPTH + 1),
    localparam int AddrWidth  = $clog2(STACK_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  op_t                          item_op,
    input  logic signed [ValueWidth-1:0] item_value,
    output logic [CountWidth-1:0]        count_after,
    output result_t                      result
);

    // top entry held in flops; entries below it live in the RAM
    logic [CountWidth-1:0]        count_reg, count_next;
    logic signed [ValueWidth-1:0] top_val_reg, top_val_next;
    logic signed [ValueWidth-1:0] top_min_reg, top_min_next;
    logic [EntryWidth-1:0]        byp_reg;
    logic                         byp_sel_reg, byp_sel_next;

    logic                         we;
    logic [AddrWidth-1:0]         waddr;
    logic [AddrWidth-1:0]         raddr;
    logic [EntryWidth-1:0]        wdata;
    logic [EntryWidth-1:0]        rdata;
    logic [EntryWidth-1:0]        below;
    logic [CountWidth-1:0]        count_dec;
    logic [CountWidth-1:0]        count_sub2;
    logic signed [ValueWidth-1:0] new_min;
    logic                         is_full;
    logic                         is_zero;
    err_t                         err;

    assign is_full   = (count_reg == CountWidth'(STACK_DEPTH));
    assign is_zero   = (count_reg == '0);
    assign count_dec = count_reg - CountWidth'(1);
    assign waddr     = count_dec[AddrWidth-1:0];
    assign wdata     = {top_val_reg, top_min_reg};
    assign below     = byp_sel_reg ? byp_reg : rdata;
    assign new_min   = (!is_zero && (top_min_reg < item_value)) ? top_min_reg : item_value;

    always_comb
    begin
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        we           = 1'b0;
        err          = ERR_OK;
        if (item_valid)
        begin
            unique case (item_op)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        err = ERR_FULL;
                    end
                    else
                    begin
                        we           = !is_zero;
                        top_val_next = item_value;
                        top_min_next = new_min;
                        count_next   = count_reg + CountWidth'(1);
                    end
                end
                OP_POP:
                begin
                    if (is_zero)
                    begin
                        err = ERR_EMPTY;
                    end
                    else
                    begin
                        top_val_next = below[EntryWidth-1:ValueWidth];
                        top_min_next = below[ValueWidth-1:0];
                        count_next   = count_dec;
                    end
                end
                default:
                begin
                    if (is_zero)
                    begin
                        err = ERR_EMPTY;
                    end
                end
            endcase
        end
    end

    // prefetch the entry under the new top; forward a write to the same slot
    assign count_sub2   = count_next - CountWidth'(2);
    assign raddr        = count_sub2[AddrWidth-1:0];
    assign byp_sel_next = we && (waddr == raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            byp_sel_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            byp_sel_reg <= byp_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
        if (we)
        begin
            byp_reg <= wdata;
        end
    end

    mts_ram #(
        .WIDTH (EntryWidth),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign count_after       = count_next;
    assign result.top_value  = (count_next != '0) ? top_val_next : '0;
    assign result.min_value  = (count_next != '0) ? top_min_next : '0;
    assign result.error_code = err;

endmodule

### rtl/min_tracking_stack_unit.sv
// Stack of signed 32-bit values that also reports its running minimum.
// Command channel: drive op (0 push, 1 pop, 2 peek) and push_value with
// start high; the command is taken on any edge where start is high and
// busy is low. busy is always low, so one command may be issued every
// cycle, back to back.
// Result channel: done pulses for one cycle with top_value, min_value,
// depth, is_empty and error_code describing the stack after the command.
// There is no back-pressure; each result must be taken in its done cycle.
// The command passes an input register, then a result register, before
// done rises with the result. Throughput is one command per cycle:
// the top entry is held in flops and the entry below it is prefetched
// from a single-port-read RAM, so a pop never stalls the command flow.
// Errors (pop or peek on empty, push when full) leave the stack unchanged.
// Reset empties the stack at once; RAM contents are not cleared and
// never need to be.
module min_tracking_stack_unit
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    localparam int CountWidth = $clog2(STACK_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic signed [ValueWidth-1:0] push_value,
    output logic                         done,
    output logic signed [ValueWidth-1:0] top_value,
    output logic signed [ValueWidth-1:0] min_value,
    output logic [CountWidth-1:0]        depth,
    output logic                         is_empty,
    output logic [1:0]                   error_code
);

    logic                         in_valid_reg;
    op_t                          op_reg;
    logic signed [ValueWidth-1:0] value_reg;

    logic                         done_reg;
    result_t                      res_reg;
    logic [CountWidth-1:0]        depth_reg;

    result_t                      res_next;
    logic [CountWidth-1:0]        depth_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= op_t'(op);
            value_reg <= push_value;
        end
        if (in_valid_reg)
        begin
            res_reg   <= res_next;
            depth_reg <= depth_next;
        end
    end

    mts_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_valid_reg),
        .item_op     (op_reg),
        .item_value  (value_reg),
        .count_after (depth_next),
        .result      (res_next)
    );

    assign done       = done_reg;
    assign top_value  = res_reg.top_value;
    assign min_value  = res_reg.min_value;
    assign depth      = depth_reg;
    assign is_empty   = (depth_reg == '0);
    assign error_code = res_reg.error_code;

endmodule

### tb/sv/min_tracking_stack_checker.sv
`timescale 1ns / 100ps

module min_tracking_stack_checker
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    localparam int CountWidth = $clog2(STACK_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   op,
    input  logic signed [ValueWidth-1:0] push_value,
    input  logic                         done,
    input  logic signed [ValueWidth-1:0] top_value,
    input  logic signed [ValueWidth-1:0] min_value,
    input  logic [CountWidth-1:0]        depth,
    input  logic                         is_empty,
    input  logic [1:0]                   error_code,
    output int                           results_seen,
    output int                           mismatches
);

    typedef struct {
        logic signed [ValueWidth-1:0] top;
        logic signed [ValueWidth-1:0] low;
        logic [CountWidth-1:0]        count;
        logic                         empty;
        err_t                         err;
    } stack_view_t;

    logic signed [ValueWidth-1:0] entries   [STACK_DEPTH];
    logic signed [ValueWidth-1:0] floor_min [STACK_DEPTH];
    int                           held;
    stack_view_t                  views_due [$];

    function automatic stack_view_t apply_command(input logic [1:0] cmd,
                                                  input logic signed [ValueWidth-1:0] value);
        stack_view_t                  v;
        logic signed [ValueWidth-1:0] running;
        v.err = ERR_OK;
        if (cmd == OP_PUSH)
        begin
            if (held >= STACK_DEPTH)
                v.err = ERR_FULL;
            else
            begin
                running = value;
                if (held > 0 && floor_min[held-1] < value)
                    running = floor_min[held-1];
                entries[held]   = value;
                floor_min[held] = running;
                held++;
            end
        end
        else if (cmd == OP_POP)
        begin
            if (held == 0)
                v.err = ERR_EMPTY;
            else
                held--;
        end
        else
        begin
            // peek, and the spare code acts as peek
            if (held == 0)
                v.err = ERR_EMPTY;
        end
        v.top   = (held > 0) ? entries[held-1]   : '0;
        v.low   = (held > 0) ? floor_min[held-1] : '0;
        v.count = CountWidth'(held);
        v.empty = (held == 0);
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic check_result();
        stack_view_t want;
        if (views_due.size() == 0)
            report_mismatch($sformatf("result transfer with none due: top %0d depth %0d",
                                      top_value, depth));
        else
        begin
            want = views_due.pop_front();
            compare_field("top_value",  top_value,  want.top);
            compare_field("min_value",  min_value,  want.low);
            compare_field("depth",      depth,      want.count);
            compare_field("is_empty",   is_empty,   want.empty);
            compare_field("error_code", error_code, want.err);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            views_due.delete();
            mismatches = 0;
            results_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                check_result();
                results_seen <= results_seen + 1;
            end
            if (start && !busy)
                views_due.push_back(apply_command(op, push_value));
        end
    end

endmodule

### tb/sv/min_tracking_stack_unit_test.sv
`timescale 1ns / 100ps

module min_tracking_stack_unit_test;
    import mts_pkg::*;

    localparam int StackDepth = 256;
    localparam int CountWidth = $clog2(StackDepth + 1);
    localparam logic [1:0] OpSpare = 2'd3;
    localparam int PhaseItems = 240;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   op;
    logic signed [ValueWidth-1:0] push_value;
    logic                         done;
    logic signed [ValueWidth-1:0] top_value;
    logic signed [ValueWidth-1:0] min_value;
    logic [CountWidth-1:0]        depth;
    logic                         is_empty;
    logic [1:0]                   error_code;

    int results_seen;
    int mismatches;
    int sent;
    int held;
    int sender_idle_pct;
    int idle_plan [4] = '{0, 84, 0, 19};

    min_tracking_stack_unit #(
        .STACK_DEPTH(StackDepth)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .push_value (push_value),
        .done       (done),
        .top_value  (top_value),
        .min_value  (min_value),
        .depth      (depth),
        .is_empty   (is_empty),
        .error_code (error_code)
    );

    min_tracking_stack_checker #(
        .STACK_DEPTH(StackDepth)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .push_value   (push_value),
        .done         (done),
        .top_value    (top_value),
        .min_value    (min_value),
        .depth        (depth),
        .is_empty     (is_empty),
        .error_code   (error_code),
        .results_seen (results_seen),
        .mismatches   (mismatches)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // extremes, zero, minus one and small values so that ties are common
    function automatic logic signed [ValueWidth-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return $urandom_range(16) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [1:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return OP_PUSH;
        else if (roll < 83)
            return OP_POP;
        else if (roll < 95)
            return OP_PEEK;
        else
            return OpSpare;
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input logic signed [ValueWidth-1:0] value);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        op         <= cmd;
        push_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (cmd == OP_PUSH && held < StackDepth)
            held++;
        else if (cmd == OP_POP && held > 0)
            held--;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (results_seen < sent)
            @(posedge clk);
    endtask

    task automatic fill_stack();
        while (held < StackDepth)
            send_cmd(OP_PUSH, pick_value());
        repeat ($urandom_range(1, 3))
            send_cmd(OP_PUSH, pick_value());
    endtask

    task automatic drain_stack();
        while (held > 0)
            send_cmd(OP_POP, $urandom());
        repeat ($urandom_range(1, 3))
            send_cmd($urandom_range(1) ? OP_POP : OP_PEEK, $urandom());
    endtask

    task automatic run_phase(input int idle_pct, input bit fill_first);
        int first_sent;
        int unsigned kind;
        sender_idle_pct = idle_pct;
        first_sent = sent;
        if (fill_first)
            fill_stack();
        while (sent - first_sent < PhaseItems)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                repeat ($urandom_range(20, 60))
                    send_cmd(pick_op(), pick_value());
            end
            else if (kind < 75)
                fill_stack();
            else
                drain_stack();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_PEEK;
        push_value = '0;
        sent = 0;
        held = 0;
        sender_idle_pct = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // empty-stack errors, extremes, ties and unwinding the minimum
        send_cmd(OP_PEEK, 32'sd11);
        send_cmd(OP_POP, 32'sd12);
        send_cmd(OpSpare, 32'sd13);
        send_cmd(OP_PUSH, 32'sd5);
        send_cmd(OP_PUSH, 32'sd5);
        send_cmd(OP_PUSH, 32'sd7);
        send_cmd(OP_PUSH, 32'sh7fffffff);
        send_cmd(OP_PUSH, 32'sh80000000);
        send_cmd(OP_PEEK, '0);
        send_cmd(OpSpare, '1);
        send_cmd(OP_PUSH, '0);
        send_cmd(OP_PUSH, '1);
        send_cmd(OP_PUSH, 32'sh80000000);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_PEEK, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_PUSH, '1);
        send_cmd(OP_POP, '1);
        wait_drained();

        foreach (idle_plan[i])
        begin
            run_phase(idle_plan[i], i == 0);
            wait_drained();
        end

        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
